/* rtl/core/rbr_pkg.sv */
// ============================================================================
// rbr_pkg : shared types and constants for the RGB brightness retarget
// Channel, level and arithmetic widths, plus the fixed scale constants.
// ============================================================================
package rbr_pkg;

    localparam int unsigned CHAN_W  = 8;   // one colour channel
    localparam int unsigned STEP_W  = 8;   // signed brightness step
    localparam int unsigned LEVEL_W = 7;   // level in percent, 1..100
    localparam int unsigned PROD_W  = 15;  // channel * level, below 2^15
    localparam int unsigned DEN_W   = 15;  // 100 * peak, below 2^15
    localparam int unsigned NUM_W   = 23;  // channel * 255 * level, below 2^23
    localparam int unsigned QUO_W   = 8;   // quotient bits, one per divide stage
    localparam int unsigned NCHAN   = 3;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [LEVEL_W-1:0] MIN_LEVEL  = 7'd1;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [DEN_W-1:0]   t_den;
    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [QUO_W-1:0]   t_quo;

endpackage

/* rtl/core/rgb_brightness_retarget.sv */
// ============================================================================
// rgb_brightness_retarget : HSV value retarget of one 8-bit RGB pixel
// Keeps hue and saturation, sets value to level/100, exact integer result.
// ============================================================================
// Usage
//   Input: drive i_red_in, i_green_in, i_blue_in and i_level_step with start
//   high; the item is taken at any rising edge where start is high and busy
//   is low. busy is high only around reset, so after reset one pixel may be
//   presented every clock.
//   Level: 100 + step, saturated to 1..100, reported on o_level_used.
//   Channels: each c becomes floor(c*255*level / (100*max)), max being the
//   largest input channel; a black pixel gives floor(255*level/100) on all
//   three channels.
//   Output: o_strobe is high for exactly one cycle with the result fields;
//   the receiver cannot hold results off and must take them then.
//   Pipeline: three front stages (clamp/peak, multiply, scale by 255) and one
//   stage per quotient bit of an eight-stage restoring divider lie between
//   the accepting edge and the strobe cycle.
//   Throughput: one pixel per clock while busy is low; every stage carries its own valid bit.
//   Reset: synchronous, active low; all valid bits clear, in-flight items are
//   dropped, and busy is a registered copy of reset, so it lags the release.
// ============================================================================
module rgb_brightness_retarget (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rbr_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [rbr_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [rbr_pkg::CHAN_W-1:0]  i_blue_in,
    input  logic [rbr_pkg::STEP_W-1:0]  i_level_step,
    output logic                        o_strobe,
    output logic [rbr_pkg::CHAN_W-1:0]  o_red_out,
    output logic [rbr_pkg::CHAN_W-1:0]  o_green_out,
    output logic [rbr_pkg::CHAN_W-1:0]  o_blue_out,
    output logic [rbr_pkg::LEVEL_W-1:0] o_level_used
);

    localparam int unsigned QW = rbr_pkg::QUO_W;
    localparam int unsigned NW = rbr_pkg::NUM_W;
    localparam int unsigned NC = rbr_pkg::NCHAN;

    // ------------------------------------------------------------------
    // Busy: high while in reset and for the first cycle after it
    // ------------------------------------------------------------------
    logic r_busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        r_busy <= ~i_rst_n;
    end

    assign busy   = r_busy;
    assign accept = start & ~r_busy;

    // ------------------------------------------------------------------
    // Front end: level clamp and peak search (combinational on the inputs)
    // ------------------------------------------------------------------
    logic signed [rbr_pkg::STEP_W:0] lvl_sum;
    rbr_pkg::t_level                 lvl_clamped;
    rbr_pkg::t_chan                  peak_rg;
    rbr_pkg::t_chan                  peak;
    logic                            is_black;
    rbr_pkg::t_chan                  chan_in [NC];

    assign lvl_sum = $signed({i_level_step[rbr_pkg::STEP_W-1], i_level_step})
                   + $signed({2'b00, rbr_pkg::FULL_LEVEL});

    always_comb begin
        priority if (lvl_sum <= 0) begin
            lvl_clamped = rbr_pkg::MIN_LEVEL;
        end else if (lvl_sum >= $signed({2'b00, rbr_pkg::FULL_LEVEL})) begin
            lvl_clamped = rbr_pkg::FULL_LEVEL;
        end else begin
            lvl_clamped = lvl_sum[rbr_pkg::LEVEL_W-1:0];
        end
    end

    assign peak_rg  = (i_green_in > i_red_in) ? i_green_in : i_red_in;
    assign peak     = (i_blue_in > peak_rg) ? i_blue_in : peak_rg;
    assign is_black = (peak == '0);

    assign chan_in[0] = i_red_in;
    assign chan_in[1] = i_green_in;
    assign chan_in[2] = i_blue_in;

    // ------------------------------------------------------------------
    // Stage 1: registered inputs. A black pixel is replaced by c = max = 1,
    // which gives floor(255*level/100) through the same datapath.
    // ------------------------------------------------------------------
    logic            r_s1_vld;
    rbr_pkg::t_chan  r_s1_chan [NC];
    rbr_pkg::t_chan  r_s1_peak;
    rbr_pkg::t_level r_s1_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        for (int i = 0; i < NC; i++) begin
            r_s1_chan[i] <= is_black ? rbr_pkg::CHAN_W'(1) : chan_in[i];
        end
        r_s1_peak <= is_black ? rbr_pkg::CHAN_W'(1) : peak;
        r_s1_lvl  <= lvl_clamped;
    end

    // ------------------------------------------------------------------
    // Stage 2: channel * level and divisor 100 * max
    // ------------------------------------------------------------------
    logic            r_s2_vld;
    rbr_pkg::t_prod  r_s2_prod [NC];
    rbr_pkg::t_den   r_s2_den;
    rbr_pkg::t_level r_s2_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        for (int i = 0; i < NC; i++) begin
            r_s2_prod[i] <= rbr_pkg::PROD_W'(r_s1_chan[i])
                          * rbr_pkg::PROD_W'(r_s1_lvl);
        end
        r_s2_den <= rbr_pkg::DEN_W'(r_s1_peak) * rbr_pkg::DEN_W'(rbr_pkg::FULL_LEVEL);
        r_s2_lvl <= r_s1_lvl;
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator = prod * 255 = (prod << 8) - prod.
    // Index 0 of the divider arrays holds this stage.
    // ------------------------------------------------------------------
    logic            r_vld [QW+1];
    rbr_pkg::t_num   r_rem [QW+1][NC];
    rbr_pkg::t_quo   r_quo [QW+1][NC];
    rbr_pkg::t_den   r_den [QW+1];
    rbr_pkg::t_level r_lvl [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_s2_vld;
        end
        for (int i = 0; i < NC; i++) begin
            r_rem[0][i] <= (NW'(r_s2_prod[i]) << rbr_pkg::CHAN_W) - NW'(r_s2_prod[i]);
            r_quo[0][i] <= '0;
        end
        r_den[0] <= r_s2_den;
        r_lvl[0] <= r_s2_lvl;
    end

    // ------------------------------------------------------------------
    // Divider: restoring division, one quotient bit per stage, MSB first.
    // The quotient never exceeds 255 because every channel is at most max.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int unsigned SH = QW - 1 - j;

        logic [NW:0]   n_trial [NC];
        logic [NW:0]   dsh;
        rbr_pkg::t_num n_rem   [NC];
        logic          n_bit   [NC];

        assign dsh = {{(NW + 1 - rbr_pkg::DEN_W){1'b0}}, r_den[j]} << SH;

        for (genvar i = 0; i < NC; i++) begin : g_ch
            assign n_trial[i] = {1'b0, r_rem[j][i]} - dsh;
            assign n_bit[i]   = ~n_trial[i][NW];
            assign n_rem[i]   = n_bit[i] ? n_trial[i][NW-1:0] : r_rem[j][i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
            for (int i = 0; i < NC; i++) begin
                r_rem[j+1][i] <= n_rem[i];
                r_quo[j+1][i] <= {r_quo[j][i][QW-2:0], n_bit[i]};
            end
            r_den[j+1] <= r_den[j];
            r_lvl[j+1] <= r_lvl[j];
        end
    end

    // ------------------------------------------------------------------
    // Result ports straight from the last divider stage
    // ------------------------------------------------------------------
    assign o_strobe     = r_vld[QW];
    assign o_red_out    = r_quo[QW][0];
    assign o_green_out  = r_quo[QW][1];
    assign o_blue_out   = r_quo[QW][2];
    assign o_level_used = r_lvl[QW];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam int unsigned LAT = QW + 3;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("accepted item did not emerge after the pipeline latency");

    a_no_ghost : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted item");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (NW'(r_den[QW]) > r_rem[QW][0]) && (NW'(r_den[QW]) > r_rem[QW][1])
                  && (NW'(r_den[QW]) > r_rem[QW][2]))
        else $error("divider remainder not below the divisor");

    a_level_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_level_used >= rbr_pkg::MIN_LEVEL)
                  && (o_level_used <= rbr_pkg::FULL_LEVEL))
        else $error("applied level outside 1..100");

    a_black_grey : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_red_in == '0 && i_green_in == '0 && i_blue_in == '0)
        |-> ##LAT (o_red_out == o_green_out) && (o_green_out == o_blue_out))
        else $error("black pixel did not give equal channels");

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench : self-checking bench for rgb_brightness_retarget
// Drives pixels and brightness steps through the start/busy handshake with random
// gaps, predicts untyped pixels in exact integer arithmetic (typed rows give their
// own), and checks each strobed result, in order, against the oldest expectation.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 1280;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CHAN_FULL    = 255;
    localparam int unsigned DIR_ROWS     = 22;

    // One retargeted pixel, as it leaves the block
    typedef struct packed {
        rbr_pkg::t_chan  red;
        rbr_pkg::t_chan  green;
        rbr_pkg::t_chan  blue;
        rbr_pkg::t_level level;
    } t_pixel_result;

    // One row of the directed table; typed rows carry the result read off by hand
    typedef struct packed {
        rbr_pkg::t_chan             red;
        rbr_pkg::t_chan             green;
        rbr_pkg::t_chan             blue;
        logic [rbr_pkg::STEP_W-1:0] step;
        bit                         typed;
        t_pixel_result              want;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    rbr_pkg::t_chan             i_red_in;
    rbr_pkg::t_chan             i_green_in;
    rbr_pkg::t_chan             i_blue_in;
    logic [rbr_pkg::STEP_W-1:0] i_level_step;
    logic                       o_strobe;
    rbr_pkg::t_chan             o_red_out;
    rbr_pkg::t_chan             o_green_out;
    rbr_pkg::t_chan             o_blue_out;
    rbr_pkg::t_level            o_level_used;

    // Predicted pixels, oldest first
    t_pixel_result      pending_pixels [$];
    // Driver side of the item currently offered
    bit                 cur_typed;
    t_pixel_result      cur_want;
    // Set at each rising edge that took an item; read by the driver at the falling edge
    bit                 took_item;
    int unsigned        burst_left;
    int unsigned        fault_count;

    // Directed part: black, white and grey pixels, pure primaries, and the
    // level clamps at both ends (step of zero or more, step of -100 or less).
    t_stim_row dir_rows [DIR_ROWS] = '{
        // black pixel: all channels become floor(255 * level / 100)
        '{8'd0,   8'd0,   8'd0,   8'd0,      1'b1, '{8'd255, 8'd255, 8'd255, 7'd100}},
        '{8'd0,   8'd0,   8'd0,   8'(-128),  1'b1, '{8'd2,   8'd2,   8'd2,   7'd1}},
        '{8'd0,   8'd0,   8'd0,   8'd127,    1'b1, '{8'd255, 8'd255, 8'd255, 7'd100}},
        '{8'd0,   8'd0,   8'd0,   8'(-1),    1'b1, '{8'd252, 8'd252, 8'd252, 7'd99}},
        // white and the lower clamp just past its edge
        '{8'd255, 8'd255, 8'd255, 8'd0,      1'b1, '{8'd255, 8'd255, 8'd255, 7'd100}},
        '{8'd255, 8'd255, 8'd255, 8'(-101),  1'b1, '{8'd2,   8'd2,   8'd2,   7'd1}},
        // primaries and the smallest nonzero channel
        '{8'd1,   8'd0,   8'd0,   8'(-128),  1'b1, '{8'd2,   8'd0,   8'd0,   7'd1}},
        '{8'd255, 8'd0,   8'd0,   8'd0,      1'b1, '{8'd255, 8'd0,   8'd0,   7'd100}},
        '{8'd0,   8'd255, 8'd0,   8'd1,      1'b1, '{8'd0,   8'd255, 8'd0,   7'd100}},
        '{8'd0,   8'd0,   8'd255, 8'(-100),  1'b1, '{8'd0,   8'd0,   8'd2,   7'd1}},
        // grey pixels, a middle level, and levels next to both clamps
        '{8'd1,   8'd1,   8'd1,   8'd0,      1'b0, '0},
        '{8'd100, 8'd100, 8'd100, 8'(-50),   1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 8'(-99),   1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 8'(-1),    1'b0, '0},
        // mixed colours
        '{8'd128, 8'd64,  8'd32,  8'(-50),   1'b0, '0},
        '{8'd255, 8'd128, 8'd1,   8'(-1),    1'b0, '0},
        '{8'd200, 8'd100, 8'd50,  8'd127,    1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   8'(-60),   1'b0, '0},
        '{8'd254, 8'd255, 8'd253, 8'(-2),    1'b0, '0},
        '{8'd85,  8'd170, 8'd51,  8'(-127),  1'b0, '0},
        '{8'd255, 8'd254, 8'd0,   8'(-98),   1'b0, '0},
        '{8'd3,   8'd2,   8'd1,   8'(-33),   1'b0, '0}
    };

    rgb_brightness_retarget u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_level_step (i_level_step),
        .o_strobe     (o_strobe),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_level_used (o_level_used)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Scale one channel by 255 * level / (100 * peak); a black pixel takes the full scale
    function automatic rbr_pkg::t_chan scale_chan(int unsigned c, int unsigned peak,
                                                  int unsigned lvl);
        int unsigned q;
        if (peak == 0)
            q = (CHAN_FULL * lvl) / rbr_pkg::FULL_LEVEL;
        else
            q = (c * CHAN_FULL * lvl) / (rbr_pkg::FULL_LEVEL * peak);
        return rbr_pkg::t_chan'(q);
    endfunction

    // Predict the pixel that a given input and step must produce
    function automatic t_pixel_result retarget_pixel(rbr_pkg::t_chan r,
                                                     rbr_pkg::t_chan g,
                                                     rbr_pkg::t_chan b,
                                                     logic [rbr_pkg::STEP_W-1:0] step);
        int            sum;
        int unsigned   lvl;
        int unsigned   peak;
        t_pixel_result res;
        sum = int'(rbr_pkg::FULL_LEVEL) + int'($signed(step));
        if (sum <= 0)
            lvl = rbr_pkg::MIN_LEVEL;
        else if (sum >= int'(rbr_pkg::FULL_LEVEL))
            lvl = rbr_pkg::FULL_LEVEL;
        else
            lvl = sum;
        peak = r;
        if (g > peak) peak = g;
        if (b > peak) peak = b;
        res.red   = scale_chan(r, peak, lvl);
        res.green = scale_chan(g, peak, lvl);
        res.blue  = scale_chan(b, peak, lvl);
        res.level = rbr_pkg::t_level'(lvl);
        return res;
    endfunction

    // Offer one item at a falling edge after a random gap, and hold it until taken.
    // Runs of back-to-back items are mixed in so that the pipeline fills up.
    task automatic present_item(rbr_pkg::t_chan r, rbr_pkg::t_chan g, rbr_pkg::t_chan b,
                                logic [rbr_pkg::STEP_W-1:0] step,
                                bit typed, t_pixel_result want);
        int unsigned gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_red_in     = r;
        i_green_in   = g;
        i_blue_in    = b;
        i_level_step = step;
        cur_typed    = typed;
        cur_want     = want;
        start        = 1'b1;
        do @(negedge i_clk); while (!took_item);
    endtask

    // Take items and strobed results at the rising edge
    always @(posedge i_clk) begin : result_check
        t_pixel_result want;
        t_pixel_result got;
        took_item <= i_rst_n && start && (busy === 1'b0);
        // Predict as each item is taken; typed rows bring their own answer
        if (i_rst_n && start && (busy === 1'b0)) begin
            if (cur_typed)
                pending_pixels.push_back(cur_want);
            else
                pending_pixels.push_back(retarget_pixel(i_red_in, i_green_in, i_blue_in,
                                                        i_level_step));
        end
        // Treat an unknown strobe as a result so that it cannot slip by
        if (i_rst_n && o_strobe !== 1'b0) begin
            got = '{o_red_out, o_green_out, o_blue_out, o_level_used};
            if (pending_pixels.size() == 0) begin
                fault_count++;
                $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d lvl=%0d",
                         $time, got.red, got.green, got.blue, got.level);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    fault_count++;
                    $display("%0t: mismatch: expected r=%0d g=%0d b=%0d lvl=%0d,",
                             $time, want.red, want.green, want.blue, want.level,
                             " got r=%0d g=%0d b=%0d lvl=%0d",
                             got.red, got.green, got.blue, got.level);
                end
            end
        end
    end

    // Stimulus: reset once, then the directed table, then random pixels
    initial begin : stimulus
        rbr_pkg::t_chan             r;
        rbr_pkg::t_chan             g;
        rbr_pkg::t_chan             b;
        logic [rbr_pkg::STEP_W-1:0] step;
        start        = 1'b0;
        i_red_in     = '0;
        i_green_in   = '0;
        i_blue_in    = '0;
        i_level_step = '0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        burst_left   = 0;
        fault_count  = 0;
        i_rst_n      = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            present_item(dir_rows[k].red, dir_rows[k].green, dir_rows[k].blue,
                         dir_rows[k].step, dir_rows[k].typed, dir_rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Pick a pixel shape: black, grey, one channel at full, tiny, or anything
            r = rbr_pkg::t_chan'($urandom_range(0, 255));
            g = rbr_pkg::t_chan'($urandom_range(0, 255));
            b = rbr_pkg::t_chan'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0: begin
                    r = '0; g = '0; b = '0;
                end
                1: begin
                    g = r; b = r;
                end
                2: begin
                    case ($urandom_range(0, 2))
                        0:       r = rbr_pkg::t_chan'(CHAN_FULL);
                        1:       g = rbr_pkg::t_chan'(CHAN_FULL);
                        default: b = rbr_pkg::t_chan'(CHAN_FULL);
                    endcase
                end
                3: begin
                    r = rbr_pkg::t_chan'($urandom_range(0, 3));
                    g = rbr_pkg::t_chan'($urandom_range(0, 3));
                    b = rbr_pkg::t_chan'($urandom_range(0, 3));
                end
                default: ;
            endcase
            // Steps: anything, a drop of 0..100 across the levels, a clamp edge, or a drop of 0..128
            case ($urandom_range(0, 3))
                0: step = rbr_pkg::STEP_W'($urandom_range(0, 255));
                1: step = rbr_pkg::STEP_W'(-int'($urandom_range(0, 100)));
                2: begin
                    case ($urandom_range(0, 7))
                        0:       step = rbr_pkg::STEP_W'(-128);
                        1:       step = rbr_pkg::STEP_W'(-101);
                        2:       step = rbr_pkg::STEP_W'(-100);
                        3:       step = rbr_pkg::STEP_W'(-99);
                        4:       step = rbr_pkg::STEP_W'(-1);
                        5:       step = rbr_pkg::STEP_W'(0);
                        6:       step = rbr_pkg::STEP_W'(1);
                        default: step = rbr_pkg::STEP_W'(127);
                    endcase
                end
                default: step = rbr_pkg::STEP_W'(-int'($urandom_range(0, 128)));
            endcase
            present_item(r, g, b, step, 1'b0, '0);
        end

        // Drop start, let every result arrive, then watch for strays
        start = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
